@@ src/mwf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mwf_pkg;

  // Window and number formats
  localparam int WINDOW_DEPTH  = 5;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int MEAN_BITS     = SAMPLE_BITS + FRACTION_BITS;
  localparam int COUNT_BITS    = 3;
  localparam int PTR_BITS      = 3;

  // Weights fit in 7 bits (sum of all weights is 100)
  localparam int WEIGHT_BITS   = 7;
  localparam int ACC_BITS      = SAMPLE_BITS + WEIGHT_BITS;
  localparam int MAG_BITS      = ACC_BITS - 1;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS     = MEAN_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

  // Stream data widths, rounded up to whole bytes
  localparam int S_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_FIELD_BITS  = SAMPLE_BITS + MEAN_BITS + COUNT_BITS;
  localparam int M_DATA_BITS   = ((M_FIELD_BITS + 7) / 8) * 8;

  // Weight by age: age 0 is the newest entry
  function automatic logic [WEIGHT_BITS-1:0] weight(input logic [COUNT_BITS-1:0] age);
    logic [WEIGHT_BITS-1:0] w;
    case (age)
      3'd0:    w = 7'd40;
      3'd1:    w = 7'd30;
      3'd2:    w = 7'd15;
      3'd3:    w = 7'd10;
      3'd4:    w = 7'd5;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  // Sum of the weights in use for a given fill count
  function automatic logic [WEIGHT_BITS-1:0] weight_sum(input logic [COUNT_BITS-1:0] cnt);
    logic [WEIGHT_BITS-1:0] s;
    case (cnt)
      3'd1:    s = 7'd40;
      3'd2:    s = 7'd70;
      3'd3:    s = 7'd85;
      3'd4:    s = 7'd95;
      3'd5:    s = 7'd100;
      default: s = 7'd40;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/median_weighted_window_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Median and weighted moving average over a five-sample window.
// Input stream (s_axis_*): one signed sample per transaction. The sample is
// written into a circular window; up to five most recent samples are valid.
// Output stream (m_axis_*): one transaction per input, holding the median of
// the valid entries (upper middle for an even count), the weighted mean
// (weights 40/30/15/10/5, newest first) in fixed point with 8 fraction bits
// truncated toward zero, and the number of valid entries.
// Processing runs as a scan over the valid entries with one shared
// multiply-accumulate and rank compare, a setup step (ST_PREP), the
// restoring divider (one quotient bit per cycle) and an output step
// (ST_DONE) that loads the output register. s_axis_tready is high only
// while idle, so a new sample is accepted only after the previous result
// has been loaded into the output register and the state is back to idle.
// Reset empties the window and clears both channels. If the receiver stalls,
// the finished result waits in the output register; a new sample is accepted
// meanwhile, and its result waits until the register is taken.

module median_weighted_window_filter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [mwf_pkg::S_DATA_BITS-1:0]  s_axis_tdata,  // [15:0] sample
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [15:0] median, [39:16] weighted_mean, [42:40] valid_count, rest zero
  output logic [mwf_pkg::M_DATA_BITS-1:0]       m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam int SB = mwf_pkg::SAMPLE_BITS;
  localparam int DEPTH = mwf_pkg::WINDOW_DEPTH;
  localparam logic [mwf_pkg::PTR_BITS-1:0] LAST_SLOT = mwf_pkg::PTR_BITS'(DEPTH - 1);
  localparam logic [mwf_pkg::COUNT_BITS-1:0] FULL_COUNT = mwf_pkg::COUNT_BITS'(DEPTH);
  localparam logic [mwf_pkg::DIV_CNT_BITS-1:0] DIV_LAST =
    mwf_pkg::DIV_CNT_BITS'(mwf_pkg::DIV_STEPS - 1);

  state_e state_q;

  logic signed [SB-1:0]                   win_q [DEPTH];
  logic [mwf_pkg::PTR_BITS-1:0]           wp_q;
  logic [mwf_pkg::COUNT_BITS-1:0]         fill_q;

  logic [mwf_pkg::PTR_BITS-1:0]           pos_q;
  logic [mwf_pkg::COUNT_BITS-1:0]         age_q;
  logic [mwf_pkg::COUNT_BITS-1:0]         rank_q [DEPTH];
  logic signed [mwf_pkg::ACC_BITS-1:0]    acc_q;
  logic signed [SB-1:0]                   med_q;
  logic                                   neg_q;
  logic [mwf_pkg::WEIGHT_BITS-1:0]        wsum_q;
  logic [mwf_pkg::WEIGHT_BITS-1:0]        rem_q;
  logic [mwf_pkg::MEAN_BITS-1:0]          dvd_q;
  logic [mwf_pkg::DIV_CNT_BITS-1:0]       div_cnt_q;

  logic                                   out_valid_q;
  logic [SB-1:0]                          out_med_q;
  logic [mwf_pkg::MEAN_BITS-1:0]          out_mean_q;
  logic [mwf_pkg::COUNT_BITS-1:0]         out_cnt_q;

  logic                                   s_accept;
  logic [mwf_pkg::PTR_BITS-1:0]           wp_d;
  logic [mwf_pkg::COUNT_BITS-1:0]         fill_d;
  logic signed [SB-1:0]                   entry;
  logic signed [mwf_pkg::ACC_BITS-1:0]    product;
  logic [mwf_pkg::COUNT_BITS-1:0]         rank_d [DEPTH];
  logic signed [SB-1:0]                   med_d;
  logic [mwf_pkg::COUNT_BITS-1:0]         mid_rank;
  logic [mwf_pkg::ACC_BITS-1:0]           acc_abs;
  logic [mwf_pkg::MAG_BITS-1:0]           mag;
  logic [mwf_pkg::WEIGHT_BITS:0]          trial;
  logic                                   qbit;
  logic [mwf_pkg::WEIGHT_BITS-1:0]        rem_d;
  logic [mwf_pkg::MEAN_BITS-1:0]          mean_d;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(mwf_pkg::M_DATA_BITS - mwf_pkg::M_FIELD_BITS)'(0),
                          out_cnt_q, out_mean_q, out_med_q};

  // Pointer and fill count after the insert
  assign wp_d   = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
  assign fill_d = (fill_q == FULL_COUNT) ? fill_q : fill_q + 1'b1;

  // Shared scan unit: one window entry per cycle, newest first
  assign entry   = win_q[pos_q];
  assign product = mwf_pkg::ACC_BITS'(entry * $signed({1'b0, mwf_pkg::weight(age_q)}));

  // Rank update: entries strictly above the scanned one, ties broken by slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if ((entry < win_q[i]) ||
          ((entry == win_q[i]) && (pos_q < mwf_pkg::PTR_BITS'(i)))) begin
        rank_d[i] = rank_q[i] + 1'b1;
      end else begin
        rank_d[i] = rank_q[i];
      end
    end
  end

  // Median: the valid entry whose rank is count/2
  assign mid_rank = fill_q >> 1;
  always_comb begin
    med_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((mwf_pkg::COUNT_BITS'(i) < fill_q) && (rank_q[i] == mid_rank)) begin
        med_d = win_q[i];
      end
    end
  end

  // Magnitude of the weighted sum for the unsigned divider
  assign acc_abs = acc_q[mwf_pkg::ACC_BITS-1] ? -acc_q : acc_q;
  assign mag     = acc_abs[mwf_pkg::MAG_BITS-1:0];

  // Restoring divide step
  assign trial  = {rem_q, dvd_q[mwf_pkg::MEAN_BITS-1]};
  assign qbit   = (trial >= {1'b0, wsum_q});
  assign rem_d  = qbit ? mwf_pkg::WEIGHT_BITS'(trial - {1'b0, wsum_q})
                       : trial[mwf_pkg::WEIGHT_BITS-1:0];
  assign mean_d = neg_q ? -dvd_q : dvd_q;

  // Control, window and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      // Taken result leaves the register unless a new one is loaded
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            win_q[wp_q] <= s_axis_tdata[SB-1:0];
            wp_q        <= wp_d;
            fill_q      <= fill_d;
            pos_q       <= wp_q;
            age_q       <= '0;
            acc_q       <= '0;
            for (int i = 0; i < DEPTH; i++) begin
              rank_q[i] <= '0;
            end
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          acc_q  <= acc_q + product;
          rank_q <= rank_d;
          pos_q  <= (pos_q == '0) ? LAST_SLOT : pos_q - 1'b1;
          age_q  <= age_q + 1'b1;
          if (age_q == fill_q - 1'b1) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          med_q     <= med_d;
          neg_q     <= acc_q[mwf_pkg::ACC_BITS-1];
          wsum_q    <= mwf_pkg::weight_sum(fill_q);
          rem_q     <= {1'b0, mag[mwf_pkg::MAG_BITS-1:SB]};
          dvd_q     <= mwf_pkg::MEAN_BITS'(mag[SB-1:0]) << mwf_pkg::FRACTION_BITS;
          div_cnt_q <= '0;
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          rem_q     <= rem_d;
          dvd_q     <= {dvd_q[mwf_pkg::MEAN_BITS-2:0], qbit};
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DIV_LAST) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_med_q   <= med_q;
            out_mean_q  <= mean_d;
            out_cnt_q   <= fill_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Fill count never passes the window depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_COUNT)
    else $error("fill count beyond window depth");

  // Write pointer stays within the window
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LAST_SLOT)
    else $error("write pointer out of range");

  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < wsum_q))
    else $error("divider remainder not below divisor");

  // A delivered result never reports an empty window
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_cnt_q != '0) && (out_cnt_q <= FULL_COUNT)))
    else $error("result count out of range");

  // Input is only taken when the scan can start on a non-empty window next
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> ((state_q == ST_SCAN) && (fill_q != '0)))
    else $error("scan did not start after input transaction");

endmodule

`default_nettype wire

@@ bench/mwf_window_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels of the filter. Every accepted sample updates a
// private copy of the window and queues the expected median, weighted mean
// and fill count. Every accepted output transaction is checked against the
// oldest queued entry.
module mwf_window_checker
  import mwf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  input  wire logic [S_DATA_BITS-1:0] s_tdata_i,   // [15:0] sample
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tready_i,
  // [15:0] median, [39:16] weighted_mean, [42:40] valid_count, rest zero
  input  wire logic [M_DATA_BITS-1:0] m_tdata_i,
  output int                          mismatch_count_o,
  output int                          outstanding_o
);

  typedef struct packed {
    logic [COUNT_BITS-1:0]           count;
    logic signed [MEAN_BITS-1:0]     mean;
    logic signed [SAMPLE_BITS-1:0]   median;
  } window_stats_t;

  // Private copy of the window
  logic signed [SAMPLE_BITS-1:0] window_q [WINDOW_DEPTH];
  int                            write_slot;
  int                            filled;

  window_stats_t                 pending_stats[$];
  int                            result_index;

  // Newest sample weighs most
  function automatic longint age_weight(input int age);
    case (age)
      0:       return 40;
      1:       return 30;
      2:       return 15;
      3:       return 10;
      default: return 5;
    endcase
  endfunction

  // Insert one sample and work out the stats over the valid entries
  function automatic window_stats_t absorb_sample(input logic signed [SAMPLE_BITS-1:0] sample);
    window_stats_t                 stats;
    logic signed [SAMPLE_BITS-1:0] ordered [WINDOW_DEPTH];
    logic signed [SAMPLE_BITS-1:0] held;
    longint                        weighted_acc;
    longint                        weight_total;
    longint                        quotient;
    int                            i;
    int                            j;
    int                            slot;

    window_q[write_slot] = sample;
    write_slot = (write_slot + 1) % WINDOW_DEPTH;
    if (filled < WINDOW_DEPTH) filled++;

    // Ascending insertion sort of slots 0..filled-1
    for (i = 0; i < filled; i++) begin
      held = window_q[i];
      j = i;
      while (j > 0 && ordered[j-1] > held) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = held;
    end

    // Walk back from the newest entry
    weighted_acc = 0;
    weight_total = 0;
    slot = (write_slot + WINDOW_DEPTH - 1) % WINDOW_DEPTH;
    for (i = 0; i < filled; i++) begin
      weighted_acc += longint'(window_q[slot]) * age_weight(i);
      weight_total += age_weight(i);
      slot = (slot + WINDOW_DEPTH - 1) % WINDOW_DEPTH;
    end
    // Signed division truncates toward zero
    quotient = (weighted_acc * (longint'(1) << FRACTION_BITS)) / weight_total;

    stats.median = ordered[filled / 2];
    stats.mean   = quotient[MEAN_BITS-1:0];
    stats.count  = COUNT_BITS'(filled);
    return stats;
  endfunction

  function automatic void flag_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("result %0d %s: expected %0d, got %0d", result_index, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) window_q[k] = '0;
      write_slot       = 0;
      filled           = 0;
      result_index     = 0;
      mismatch_count_o = 0;
      pending_stats.delete();
      outstanding_o   <= 0;
    end else begin
      // Output transaction: compare with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (pending_stats.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("result %0d: unexpected transaction %0h", result_index, m_tdata_i);
        end else begin
          window_stats_t want;
          want = pending_stats.pop_front();
          flag_field("median", int'(want.median),
                     int'($signed(m_tdata_i[SAMPLE_BITS-1:0])));
          flag_field("weighted_mean", int'(want.mean),
                     int'($signed(m_tdata_i[SAMPLE_BITS +: MEAN_BITS])));
          flag_field("valid_count", int'(want.count),
                     int'(m_tdata_i[SAMPLE_BITS+MEAN_BITS +: COUNT_BITS]));
          flag_field("padding", 0, int'(m_tdata_i[M_DATA_BITS-1:M_FIELD_BITS]));
        end
        result_index++;
      end
      // Input transaction: predict its result
      if (s_tvalid_i && s_tready_i)
        pending_stats.push_back(absorb_sample(s_tdata_i[SAMPLE_BITS-1:0]));
      outstanding_o <= pending_stats.size();
    end
  end

endmodule

@@ bench/median_weighted_window_filter_tb.sv @@
`timescale 1ns / 1ps

// Drives samples into the filter under several idle/stall mixes and reports
// the verdict from the checker's mismatch and outstanding counts.
module median_weighted_window_filter_tb;
  import mwf_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int ITEMS_PER_PHASE  = 440;
  localparam int SETTLE_CYCLES    = 40;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_DATA_BITS-1:0] s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_axis_tdata;

  int unsigned            send_idle_pct = 0;
  int unsigned            recv_stall_pct = 0;
  int                     cycle_count = 0;
  int                     mismatch_count;
  int                     outstanding;

  logic [SAMPLE_BITS-1:0] directed_samples [$];
  logic [SAMPLE_BITS-1:0] prev_sample;

  median_weighted_window_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mwf_window_checker window_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Servo-like sample mix: wide random, extremes, small values near zero,
  // holds and ramps around the previous sample
  function automatic logic [SAMPLE_BITS-1:0] next_servo_sample(input logic [SAMPLE_BITS-1:0] prev);
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = SAMPLE_BITS'($urandom);
      4:          v = SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
      5:          v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      6:          v = $urandom_range(0, 1) ? SAMPLE_BITS'(16'h7FFF - $urandom_range(0, 15))
                                           : SAMPLE_BITS'(16'h8000 + $urandom_range(0, 15));
      7:          v = prev;
      8:          v = prev + SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      default:    v = SAMPLE_BITS'(int'($urandom_range(0, 600)) - 300);
    endcase
    return v;
  endfunction

  // One input transaction, then an optional idle gap
  task automatic drive_sample(input logic [SAMPLE_BITS-1:0] value);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_BITS'(value);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // Gap lengths spread across the whole processing span of an item
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 45);
      repeat (gap) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every predicted result has been taken
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    // Window fill with alternating extremes, then full-scale runs, then
    // small values that exercise truncation of negative means
    directed_samples = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                         16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                         16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE, 16'h0003,
                         16'h0002};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_samples[i]) drive_sample(directed_samples[i]);
    drain_results();

    prev_sample = '0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        prev_sample = next_servo_sample(prev_sample);
        drive_sample(prev_sample);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
src/mwf_pkg.sv
src/median_weighted_window_filter.sv
bench/mwf_window_checker.sv
bench/median_weighted_window_filter_tb.sv
